// ===== hw/rtl/dcdc_keepalive_supervisor_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the keepalive supervisor.
// Both macros sample on aclk and are disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef DCDC_KEEPALIVE_SUPERVISOR_UNIT_DEFINES_SVH
`define DCDC_KEEPALIVE_SUPERVISOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DKS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dks_pkg.sv =====
// ---------------------------------------------------------------------------
// dks_pkg
// Types, codes and constants shared by the keepalive supervisor modules.
// ---------------------------------------------------------------------------
`default_nettype none

package dks_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_LIMIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_ENABLE      = 3'd4;

    // Register reset values.
    localparam logic [10:0] SOC_LIMIT_TENTHS_RST = 11'd200;
    localparam logic [14:0] START_THRESHOLD_RST  = 15'd12200;

    // Timing and threshold constants.
    localparam logic [15:0] MS_PER_MIN       = 16'd60000;
    localparam logic [31:0] NO_CURRENT_MS    = 32'd60000;
    localparam logic [31:0] AUTO_LIMIT_MS    = 32'd1800000;
    localparam logic signed [16:0] CURRENT_SEEN_MA = 17'sd500;
    localparam logic [3:0]  TENTHS_PER_PCT   = 4'd10;

    typedef enum logic [1:0] {
        CMD_CHECK     = 2'd0,
        CMD_MANUAL_ON = 2'd1,
        CMD_DISABLE   = 2'd2,
        CMD_AFTER_IGN = 2'd3
    } dks_cmd_t;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_AUTO_START   = 4'd1,
        EV_IGN_STOP     = 4'd2,
        EV_CHG_STOP     = 4'd3,
        EV_PRE_STOP     = 4'd4,
        EV_SOC_STOP     = 4'd5,
        EV_TIME_STOP    = 4'd6,
        EV_AUTO_TIMEOUT = 4'd7,
        EV_BLOCKED      = 4'd8,
        EV_UNBLOCKED    = 4'd9,
        EV_EXT_PRE_STOP = 4'd10,
        EV_REFUSED      = 4'd11,
        EV_MANUAL_ON    = 4'd12,
        EV_DISABLED     = 4'd13
    } dks_event_t;

    // Configuration as seen by the rule logic, with limits pre-scaled.
    typedef struct packed {
        logic [10:0] soc_limit_tenths;
        logic [26:0] run_limit_ms;
        logic [14:0] start_threshold_mv;
        logic        auto_start_enable;
        logic        bus_enable;
    } dks_cfg_t;

    // One request on the input side.
    typedef struct packed {
        dks_cmd_t           command;
        logic [31:0]        now_ms;
        logic               ignition_on;
        logic               charging;
        logic               hvac_on;
        logic [9:0]         soc_tenths;
        logic [14:0]        aux_voltage_mv;
        logic signed [16:0] aux_current_ma;
    } dks_item_t;

    // Supervisor state.
    typedef struct packed {
        logic        running;
        logic        manual_flag;
        logic        auto_started_flag;
        logic        current_seen;
        logic        after_ignition_flag;
        logic        blocked_flag;
        logic        prev_hvac;
        logic [31:0] start_time_ms;
    } dks_state_t;

    // One result.
    typedef struct packed {
        logic       active;
        logic       manual_mode;
        logic       auto_blocked;
        logic       enable_ok;
        logic       no_current_warning;
        dks_event_t event_res;
    } dks_result_t;

    // Stop everything; the blocked and last-HVAC flags are kept.
    function automatic dks_state_t stop_all(input dks_state_t s);
        dks_state_t r;
        r = s;
        r.running = 1'b0;
        r.manual_flag = 1'b0;
        r.auto_started_flag = 1'b0;
        r.current_seen = 1'b0;
        r.after_ignition_flag = 1'b0;
        r.start_time_ms = '0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dks_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// dks_cfg_regs
// Configuration registers; limits are scaled to rule units when written.
// ---------------------------------------------------------------------------
`default_nettype none

module dks_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dks_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dks_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output dks_pkg::dks_cfg_t                   cfg
);
    import dks_pkg::*;

    dks_cfg_t cfg_reg;

    // Register write; the SOC limit is kept in tenths and the time limit in ms.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.soc_limit_tenths   <= SOC_LIMIT_TENTHS_RST;
            cfg_reg.run_limit_ms       <= '0;
            cfg_reg.start_threshold_mv <= START_THRESHOLD_RST;
            cfg_reg.auto_start_enable  <= 1'b0;
            cfg_reg.bus_enable         <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SOC_LIMIT: begin
                    cfg_reg.soc_limit_tenths <=
                        11'(cfg_wdata[6:0]) * 11'(TENTHS_PER_PCT);
                end
                CFG_TIME_LIMIT: begin
                    cfg_reg.run_limit_ms <= 27'(cfg_wdata[10:0]) * 27'(MS_PER_MIN);
                end
                CFG_START_THRESHOLD: begin
                    cfg_reg.start_threshold_mv <= cfg_wdata[14:0];
                end
                CFG_AUTO_START: begin
                    cfg_reg.auto_start_enable <= cfg_wdata[0];
                end
                CFG_BUS_ENABLE: begin
                    cfg_reg.bus_enable <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dks_rules.sv =====
// ---------------------------------------------------------------------------
// dks_rules
// Single-pass rule evaluation: next state and result for one request.
// ---------------------------------------------------------------------------
`default_nettype none

module dks_rules (
    input  wire dks_pkg::dks_item_t  item,
    input  wire dks_pkg::dks_state_t state_cur,
    input  wire dks_pkg::dks_cfg_t   cfg,
    output dks_pkg::dks_state_t      state_nxt,
    output dks_pkg::dks_result_t     result
);
    import dks_pkg::*;

    logic [31:0] elapsed;
    logic        soc_low;
    logic        cur_seen_now;
    logic        time_hit;

    // Shared comparisons.
    assign elapsed      = item.now_ms - state_cur.start_time_ms;
    assign soc_low      = {1'b0, item.soc_tenths} <= cfg.soc_limit_tenths;
    assign cur_seen_now = item.aux_current_ma > CURRENT_SEEN_MA;
    assign time_hit     = (cfg.run_limit_ms != '0) && (elapsed >= 32'(cfg.run_limit_ms));

    dks_state_t s;
    dks_event_t ev;
    logic       ok;
    logic       warn;
    logic       done;
    logic       cseen;

    // Rule chain; done marks that an earlier rule already gave the event.
    always_comb begin
        s     = state_cur;
        ev    = EV_NONE;
        ok    = 1'b0;
        warn  = 1'b0;
        done  = 1'b0;
        cseen = state_cur.current_seen || cur_seen_now;
        case (item.command)
            CMD_CHECK: begin
                // Rising HVAC in after-ignition mode is an external preconditioning.
                if (!state_cur.prev_hvac && item.hvac_on && state_cur.after_ignition_flag) begin
                    s = stop_all(s);
                    s.prev_hvac = item.hvac_on;
                    ev = EV_EXT_PRE_STOP;
                    done = 1'b1;
                end
                // Stop rules while running.
                if (!done && state_cur.running) begin
                    s.current_seen = cseen;
                    if (!cseen && (elapsed >= NO_CURRENT_MS)) begin
                        if (state_cur.auto_started_flag) begin
                            s = stop_all(s);
                            s.blocked_flag = 1'b1;
                            ev = EV_BLOCKED;
                            done = 1'b1;
                        end else if (state_cur.manual_flag) begin
                            warn = 1'b1;
                            s.current_seen = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (item.ignition_on) begin
                            s = stop_all(s);
                            ev = EV_IGN_STOP;
                            done = 1'b1;
                        end else if (item.charging) begin
                            s = stop_all(s);
                            ev = EV_CHG_STOP;
                            done = 1'b1;
                        end else if (item.hvac_on && !state_cur.after_ignition_flag) begin
                            s = stop_all(s);
                            ev = EV_PRE_STOP;
                            done = 1'b1;
                        end else if (state_cur.manual_flag) begin
                            if (soc_low) begin
                                s = stop_all(s);
                                ev = EV_SOC_STOP;
                                done = 1'b1;
                            end else if (time_hit) begin
                                s = stop_all(s);
                                ev = EV_TIME_STOP;
                                done = 1'b1;
                            end
                        end else if (elapsed >= AUTO_LIMIT_MS) begin
                            s = stop_all(s);
                            ev = EV_AUTO_TIMEOUT;
                            done = 1'b1;
                        end
                    end
                end
                // Automatic start logic, gated by configuration and manual mode.
                if (!done && cfg.auto_start_enable && cfg.bus_enable && !s.manual_flag) begin
                    if (s.blocked_flag) begin
                        if (item.ignition_on || item.charging) begin
                            s.blocked_flag = 1'b0;
                            ev = EV_UNBLOCKED;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (!item.ignition_on && !item.charging && !item.hvac_on &&
                            (item.aux_voltage_mv != '0) &&
                            (item.aux_voltage_mv < cfg.start_threshold_mv) &&
                            !s.running) begin
                            s.running = 1'b1;
                            s.start_time_ms = item.now_ms;
                            s.auto_started_flag = 1'b1;
                            s.current_seen = 1'b0;
                            ev = EV_AUTO_START;
                        end
                        s.prev_hvac = item.hvac_on;
                    end
                end
            end
            CMD_MANUAL_ON: begin
                if (soc_low) begin
                    ev = EV_REFUSED;
                end else begin
                    s.manual_flag = 1'b1;
                    s.running = 1'b1;
                    s.start_time_ms = item.now_ms;
                    s.auto_started_flag = 1'b0;
                    s.current_seen = 1'b0;
                    ok = 1'b1;
                    ev = EV_MANUAL_ON;
                end
            end
            CMD_DISABLE: begin
                s = stop_all(s);
                ev = EV_DISABLED;
            end
            default: begin
                s.after_ignition_flag = 1'b1;
            end
        endcase
    end

    assign state_nxt                 = s;
    assign result.active             = s.running;
    assign result.manual_mode        = s.manual_flag;
    assign result.auto_blocked       = s.blocked_flag;
    assign result.enable_ok          = ok;
    assign result.no_current_warning = warn;
    assign result.event_res          = ev;

endmodule

`default_nettype wire

// ===== hw/rtl/dcdc_keepalive_supervisor_unit.sv =====
// ---------------------------------------------------------------------------
// dcdc_keepalive_supervisor_unit
// Keepalive supervisor for a 12 V auxiliary converter, one result per request.
// ---------------------------------------------------------------------------
// Every request on the s_ channel produces exactly one result on the m_ channel,
// via the input register and then the result register. The block takes one request
// per clock cycle unless the m_ channel stalls: rules are evaluated in a single pass
// between the input register and the result register, and the supervisor state is
// updated in the same cycle, so the next request already sees it. Config writes take
// effect in the cycle after the write and should be made while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dcdc_keepalive_supervisor_unit_defines.svh"

module dcdc_keepalive_supervisor_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [dks_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dks_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Request channel.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], ignition_on[32], charging[33], hvac_on[34],
    // soc_tenths[44:35], aux_voltage_mv[59:45], aux_current_ma[76:60], zero fill.
    input  wire logic [79:0]                    s_tdata,
    // command[1:0].
    input  wire logic [1:0]                     s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // active[0], manual_mode[1], auto_blocked[2], enable_ok[3],
    // no_current_warning[4], event_res[8:5], zero fill.
    output logic [15:0]                         m_tdata
);
    import dks_pkg::*;

    dks_cfg_t    cfg;
    dks_item_t   item_in;
    dks_item_t   item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    dks_state_t  state_reg;
    dks_state_t  state_next;
    dks_result_t result;
    dks_result_t out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        s_accept;
    logic        advance;

    // Configuration registers.
    dks_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the incoming request.
    assign item_in.command        = dks_cmd_t'(s_tuser);
    assign item_in.now_ms         = s_tdata[31:0];
    assign item_in.ignition_on    = s_tdata[32];
    assign item_in.charging       = s_tdata[33];
    assign item_in.hvac_on        = s_tdata[34];
    assign item_in.soc_tenths     = s_tdata[44:35];
    assign item_in.aux_voltage_mv = s_tdata[59:45];
    assign item_in.aux_current_ma = s_tdata[76:60];

    // Handshake: a request moves on when the result register is free or draining.
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_accept       = s_tvalid && s_tready;
    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // Rule evaluation.
    dks_rules u_rules (
        .item      (item_reg),
        .state_cur (state_reg),
        .cfg       (cfg),
        .state_nxt (state_next),
        .result    (result)
    );

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_in;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.event_res, out_reg.no_current_warning,
                       out_reg.enable_ok, out_reg.auto_blocked, out_reg.manual_mode,
                       out_reg.active};

    // Manual mode never stands without the converter running.
    `DKS_ASSERT_IMP(a_manual_runs, state_reg.manual_flag, state_reg.running, "manual without running")
    // An accepted enable reports the manual event and an active manual run.
    `DKS_ASSERT_IMP(a_enable_ok, m_tvalid && out_reg.enable_ok, (out_reg.event_res == EV_MANUAL_ON) && out_reg.active && out_reg.manual_mode, "enable_ok inconsistent")
    // State changes only when a request is evaluated.
    `DKS_ASSERT_NEXT(a_state_hold, !advance, $stable(state_reg), "state changed without a request")

endmodule

`default_nettype wire
